// ----- rtl/line_pixel_rasterizer_defines.svh -----
// Assertion macros used by the checker file of the line rasterizer.
// Each macro takes a label, the condition, the implied condition and a message.
`ifndef LINE_PIXEL_RASTERIZER_DEFINES_SVH
`define LINE_PIXEL_RASTERIZER_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define LPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define LPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define LPR_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lpr_pkg.sv -----
package lpr_pkg;

  // Width of a pixel coordinate.
  localparam int COORD_BITS = 9;
  // Error terms carry one more bit than a coordinate.
  localparam int ERR_BITS   = COORD_BITS + 1;
  localparam int COLOR_BITS = 16;

  typedef enum logic [0:0] {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  // Step direction codes.
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG  = 2'b11;

endpackage

// ----- rtl/line_pixel_rasterizer.sv -----
// Line rasterizer, one pixel per advance word.
//
// Input channel (in_*): a start word (in_op = 0) loads both endpoints and the
// color of a new line and produces no output word. Each advance word
// (in_op = 1) produces the next pixel of the line on the output channel, with
// out_last_pixel high on its final pixel. An advance word while no line is
// active is accepted and dropped. A start word during a line replaces it.
// Output channel (out_*): one registered output stage.
//
// A pixel appears on out_valid in the cycle after its advance word is
// accepted. Throughput is one word per cycle while in_stall is low, set by
// the single pass of two adds and two compares from the line state registers
// into the output register. The input side stalls only while a pixel sits in
// the output register and the receiver stalls it; otherwise a new word is
// taken in the same cycle that the previous pixel leaves.
//
// Reset (rst_n low at a clock edge) leaves the block idle with an empty output
// stage; the next advance word produces nothing until a start word arrives.
module line_pixel_rasterizer
  import lpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic [COORD_BITS-1:0] in_x_start,
  input  logic [COORD_BITS-1:0] in_y_start,
  input  logic [COORD_BITS-1:0] in_x_end,
  input  logic [COORD_BITS-1:0] in_y_end,
  input  logic [COLOR_BITS-1:0] in_line_color,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic [COLOR_BITS-1:0] out_pixel_color,
  output logic                  out_last_pixel
);

  // Line state.
  logic [COORD_BITS-1:0] cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0] cur_y_r, cur_y_nxt;
  logic [ERR_BITS-1:0]   x_error_r, x_error_nxt;
  logic [ERR_BITS-1:0]   y_error_r, y_error_nxt;
  logic [COORD_BITS-1:0] abs_dx_r, abs_dx_nxt;
  logic [COORD_BITS-1:0] abs_dy_r, abs_dy_nxt;
  logic [COORD_BITS-1:0] major_len_r, major_len_nxt;
  logic [1:0]            dir_x_r, dir_x_nxt;
  logic [1:0]            dir_y_r, dir_y_nxt;
  logic [ERR_BITS-1:0]   pixels_left_r, pixels_left_nxt;
  logic [COLOR_BITS-1:0] held_color_r, held_color_nxt;
  logic                  busy_r, busy_nxt;

  // Output stage.
  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] out_x_r, out_x_nxt;
  logic [COORD_BITS-1:0] out_y_r, out_y_nxt;
  logic [COLOR_BITS-1:0] out_color_r, out_color_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  in_accept;
  logic                  emit;
  logic [ERR_BITS-1:0]   x_sum, y_sum;
  logic [ERR_BITS-1:0]   major_ext;
  logic                  step_x, step_y;

  // The input waits only while a pixel is held by the receiver.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign emit      = in_accept && (in_op == OP_ADVANCE) && busy_r;

  // Error accumulation for the advance step. The sum stays below twice the
  // major length, so it always fits the error width.
  assign major_ext = {1'b0, major_len_r};
  assign x_sum     = x_error_r + {1'b0, abs_dx_r};
  assign y_sum     = y_error_r + {1'b0, abs_dy_r};
  assign step_x    = (x_sum >= major_ext);
  assign step_y    = (y_sum >= major_ext);

  function automatic logic [COORD_BITS-1:0] step_coord(
    input logic [COORD_BITS-1:0] c,
    input logic [1:0]            dir
  );
    logic [COORD_BITS-1:0] res;
    case (dir)
      DIR_POS: res = c + 1'b1;
      DIR_NEG: res = c - 1'b1;
      default: res = c;
    endcase
    return res;
  endfunction

  always_comb begin
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    x_error_nxt     = x_error_r;
    y_error_nxt     = y_error_r;
    abs_dx_nxt      = abs_dx_r;
    abs_dy_nxt      = abs_dy_r;
    major_len_nxt   = major_len_r;
    dir_x_nxt       = dir_x_r;
    dir_y_nxt       = dir_y_r;
    pixels_left_nxt = pixels_left_r;
    held_color_nxt  = held_color_r;
    busy_nxt        = busy_r;

    if (in_accept && (in_op == OP_START)) begin
      if (in_x_end > in_x_start) begin
        dir_x_nxt  = DIR_POS;
        abs_dx_nxt = in_x_end - in_x_start;
      end else if (in_x_end < in_x_start) begin
        dir_x_nxt  = DIR_NEG;
        abs_dx_nxt = in_x_start - in_x_end;
      end else begin
        dir_x_nxt  = DIR_NONE;
        abs_dx_nxt = '0;
      end
      if (in_y_end > in_y_start) begin
        dir_y_nxt  = DIR_POS;
        abs_dy_nxt = in_y_end - in_y_start;
      end else if (in_y_end < in_y_start) begin
        dir_y_nxt  = DIR_NEG;
        abs_dy_nxt = in_y_start - in_y_end;
      end else begin
        dir_y_nxt  = DIR_NONE;
        abs_dy_nxt = '0;
      end
      major_len_nxt   = (abs_dx_nxt > abs_dy_nxt) ? abs_dx_nxt : abs_dy_nxt;
      x_error_nxt     = '0;
      y_error_nxt     = '0;
      cur_x_nxt       = in_x_start;
      cur_y_nxt       = in_y_start;
      held_color_nxt  = in_line_color;
      pixels_left_nxt = {1'b0, major_len_nxt} + 1'b1;
      busy_nxt        = 1'b1;
    end else if (emit) begin
      x_error_nxt     = step_x ? (x_sum - major_ext) : x_sum;
      y_error_nxt     = step_y ? (y_sum - major_ext) : y_sum;
      cur_x_nxt       = step_x ? step_coord(cur_x_r, dir_x_r) : cur_x_r;
      cur_y_nxt       = step_y ? step_coord(cur_y_r, dir_y_r) : cur_y_r;
      pixels_left_nxt = pixels_left_r - 1'b1;
      busy_nxt        = (pixels_left_nxt != '0);
    end
  end

  // Output stage: loads on an emitted pixel, empties when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;
    if (in_accept) begin
      out_valid_nxt = emit;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_x_nxt     = cur_x_r;
      out_y_nxt     = cur_y_r;
      out_color_nxt = held_color_r;
      out_last_nxt  = (pixels_left_r == {{(ERR_BITS-1){1'b0}}, 1'b1});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      x_error_r     <= '0;
      y_error_r     <= '0;
      abs_dx_r      <= '0;
      abs_dy_r      <= '0;
      major_len_r   <= '0;
      dir_x_r       <= DIR_NONE;
      dir_y_r       <= DIR_NONE;
      pixels_left_r <= '0;
      held_color_r  <= '0;
      busy_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      cur_x_r       <= cur_x_nxt;
      cur_y_r       <= cur_y_nxt;
      x_error_r     <= x_error_nxt;
      y_error_r     <= y_error_nxt;
      abs_dx_r      <= abs_dx_nxt;
      abs_dy_r      <= abs_dy_nxt;
      major_len_r   <= major_len_nxt;
      dir_x_r       <= dir_x_nxt;
      dir_y_r       <= dir_y_nxt;
      pixels_left_r <= pixels_left_nxt;
      held_color_r  <= held_color_nxt;
      busy_r        <= busy_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Output payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_color_r <= out_color_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_color = out_color_r;
  assign out_last_pixel  = out_last_r;

endmodule

// ----- rtl/lpr_checker.sv -----
`include "line_pixel_rasterizer_defines.svh"

module lpr_checker
  import lpr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  in_op,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COORD_BITS-1:0] out_pixel_x,
  input logic [COORD_BITS-1:0] out_pixel_y,
  input logic [COLOR_BITS-1:0] out_pixel_color,
  input logic                  out_last_pixel
);

  logic                             in_accept;
  logic                             start_accept;
  logic                             out_held;
  logic [2*COORD_BITS+COLOR_BITS:0] out_word;

  assign in_accept    = in_valid && !in_stall;
  assign start_accept = in_accept && (in_op == OP_START);
  assign out_held     = out_valid && out_stall;
  assign out_word     = {out_pixel_x, out_pixel_y, out_pixel_color, out_last_pixel};

  // A stalled pixel word stays and does not change.
  `LPR_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_word), "stalled word changed")

  // A pixel stuck at the output blocks the input side.
  `LPR_ASSERT_NOW(a_in_blocked, out_held, in_stall, "input accepted while output word is held")

  // A start word never produces a pixel.
  `LPR_ASSERT_NEXT(a_start_silent, start_accept, !out_valid, "start word produced a pixel")

  // Reset empties the output stage.
  `LPR_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid, "output valid after reset")

endmodule

bind line_pixel_rasterizer lpr_checker u_lpr_checker (.*);

// ----- dv/tb_line_pixel_rasterizer.sv -----
module tb_line_pixel_rasterizer;
  import lpr_pkg::*;

  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  // Number of useful input words the random part aims for.
  localparam int RANDOM_WORDS = 1550;

  // One input word as the sender presents it.
  typedef struct packed {
    op_t                   op;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0] color;
  } line_word_t;

  // One pixel as it should leave the block.
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pixel_t;

  logic                  clk;
  logic                  rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_op = OP_START;
  logic [COORD_BITS-1:0] in_x_start = '0;
  logic [COORD_BITS-1:0] in_y_start = '0;
  logic [COORD_BITS-1:0] in_x_end = '0;
  logic [COORD_BITS-1:0] in_y_end = '0;
  logic [COLOR_BITS-1:0] in_line_color = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COORD_BITS-1:0] out_pixel_x;
  logic [COORD_BITS-1:0] out_pixel_y;
  logic [COLOR_BITS-1:0] out_pixel_color;
  logic                  out_last_pixel;

  line_pixel_rasterizer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .in_line_color  (in_line_color),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_pixel_color(out_pixel_color),
    .out_last_pixel (out_last_pixel)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Words waiting to be offered, and pixels waiting to come out.
  line_word_t pending_words[$];
  pixel_t     expected_pixels[$];

  int fail_count      = 0;
  int pixels_checked  = 0;
  int words_queued    = 0;

  // Shadow copy of the line state, advanced once per accepted word.
  logic [COORD_BITS-1:0] pen_x        = '0;
  logic [COORD_BITS-1:0] pen_y        = '0;
  logic [ERR_BITS-1:0]   err_x        = '0;
  logic [ERR_BITS-1:0]   err_y        = '0;
  logic [COORD_BITS-1:0] span_x       = '0;
  logic [COORD_BITS-1:0] span_y       = '0;
  logic [COORD_BITS-1:0] major_span   = '0;
  logic [1:0]            step_x       = DIR_NONE;
  logic [1:0]            step_y       = DIR_NONE;
  logic [ERR_BITS-1:0]   pixels_to_go = '0;
  logic [COLOR_BITS-1:0] ink_color    = '0;
  logic                  line_active  = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Distance between two coordinates, with the direction code of the step.
  function automatic logic [COORD_BITS-1:0] axis_span(input logic [COORD_BITS-1:0] from,
                                                      input logic [COORD_BITS-1:0] to,
                                                      output logic [1:0] dir);
    if (to > from) begin
      dir = DIR_POS;
      return to - from;
    end
    if (to < from) begin
      dir = DIR_NEG;
      return from - to;
    end
    dir = DIR_NONE;
    return '0;
  endfunction

  function automatic logic [COORD_BITS-1:0] move_coord(input logic [COORD_BITS-1:0] c,
                                                       input logic [1:0] dir);
    if (dir == DIR_POS) return c + 1'b1;
    if (dir == DIR_NEG) return c - 1'b1;
    return c;
  endfunction

  // Applies one accepted word to the shadow state. An advance word on an
  // active line queues the pixel that the block must emit for it.
  task automatic trace_word(input line_word_t w);
    pixel_t p;
    if (w.op == OP_START) begin
      span_x       = axis_span(w.x_start, w.x_end, step_x);
      span_y       = axis_span(w.y_start, w.y_end, step_y);
      major_span   = (span_x > span_y) ? span_x : span_y;
      err_x        = '0;
      err_y        = '0;
      pen_x        = w.x_start;
      pen_y        = w.y_start;
      ink_color    = w.color;
      pixels_to_go = {1'b0, major_span} + 1'b1;
      line_active  = 1'b1;
    end else if (line_active) begin
      p.x     = pen_x;
      p.y     = pen_y;
      p.color = ink_color;
      p.last  = (pixels_to_go == 1);
      expected_pixels.push_back(p);
      // An axis steps once its error term has caught up with the major span,
      // which lands the last pixel exactly on the second endpoint.
      err_x = err_x + {1'b0, span_x};
      err_y = err_y + {1'b0, span_y};
      if (err_x >= {1'b0, major_span}) begin
        err_x = err_x - {1'b0, major_span};
        pen_x = move_coord(pen_x, step_x);
      end
      if (err_y >= {1'b0, major_span}) begin
        err_y = err_y - {1'b0, major_span};
        pen_y = move_coord(pen_y, step_y);
      end
      pixels_to_go = pixels_to_go - 1'b1;
      if (pixels_to_go == 0) line_active = 1'b0;
    end
  endtask

  // Monitor. Outputs are checked before the input is traced: since the output
  // is registered, a pixel leaving at this edge never belongs to the
  // word accepted at the same edge.
  always @(posedge clk) begin : monitor
    pixel_t     want;
    line_word_t seen;
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel (%0d,%0d) with nothing expected",
                                    out_pixel_x, out_pixel_y));
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_x !== want.x)
            report_mismatch($sformatf("pixel %0d x got %0d want %0d",
                                      pixels_checked, out_pixel_x, want.x));
          if (out_pixel_y !== want.y)
            report_mismatch($sformatf("pixel %0d y got %0d want %0d",
                                      pixels_checked, out_pixel_y, want.y));
          if (out_pixel_color !== want.color)
            report_mismatch($sformatf("pixel %0d color got %h want %h",
                                      pixels_checked, out_pixel_color, want.color));
          if (out_last_pixel !== want.last)
            report_mismatch($sformatf("pixel %0d last got %b want %b",
                                      pixels_checked, out_last_pixel, want.last));
        end
        pixels_checked <= pixels_checked + 1;
      end
      if (in_valid && in_stall === 1'b0) begin
        seen.op      = op_t'(in_op);
        seen.x_start = in_x_start;
        seen.y_start = in_y_start;
        seen.x_end   = in_x_end;
        seen.y_end   = in_y_end;
        seen.color   = in_line_color;
        trace_word(seen);
      end
    end
  end

  // Sender. It works in bursts separated by idle gaps. A word on the bus is
  // held until it is taken; only then does the sender move on, so valid and
  // payload never react to stall.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : driver
    line_word_t w;
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (in_valid) pending_words.delete(0);
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words[0];
          in_valid      <= 1'b1;
          in_op         <= w.op;
          in_x_start    <= w.x_start;
          in_y_start    <= w.y_start;
          in_x_end      <= w.x_end;
          in_y_end      <= w.y_end;
          in_line_color <= w.color;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // Mostly short bursts, now and then a long run with no gaps.
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Stall density changes from phase to phase, including phases
  // with no stall at all. Once, after a few hundred pixels, it holds off for
  // a long stretch so that the output stage fills and the input backs up.
  int  phase_left = 0;
  int  stall_pct  = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;

  always @(posedge clk) begin : receiver
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && pixels_checked >= 400) begin
        hold_done = 1'b1;
        hold_left = 250;
        out_stall <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(10, 80);
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2:    stall_pct = 20;
            3:    stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end else begin
          phase_left--;
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic queue_start(input int xs, input int ys, input int xe, input int ye,
                             input int color);
    line_word_t w;
    w.op      = OP_START;
    w.x_start = COORD_BITS'(xs);
    w.y_start = COORD_BITS'(ys);
    w.x_end   = COORD_BITS'(xe);
    w.y_end   = COORD_BITS'(ye);
    w.color   = COLOR_BITS'(color);
    pending_words.push_back(w);
  endtask

  // Advance words carry random payload, which the block must ignore.
  task automatic queue_advances(input int count);
    line_word_t w;
    repeat (count) begin
      w.op      = OP_ADVANCE;
      w.x_start = COORD_BITS'($urandom);
      w.y_start = COORD_BITS'($urandom);
      w.x_end   = COORD_BITS'($urandom);
      w.y_end   = COORD_BITS'($urandom);
      w.color   = COLOR_BITS'($urandom);
      pending_words.push_back(w);
    end
  endtask

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  initial begin : stimulus
    int xs, ys, xe, ye, major, n_adv, drain;

    // Directed part. Advance words before any start must be dropped.
    queue_advances(2);
    // Single-point line: one pixel, flagged last; the next advance is idle.
    queue_start(5, 7, 5, 7, 16'hFFFF);
    queue_advances(2);
    // Full diagonal from corner to corner, cut short by a restart on the
    // opposite diagonal with the coordinate extremes swapped.
    queue_start(0, 0, COORD_MAX, COORD_MAX, 16'h0000);
    queue_advances(3);
    queue_start(COORD_MAX, 0, 0, COORD_MAX, 16'hA5A5);
    queue_advances(3);
    // Horizontal line stepping left, run to its end and one past it.
    queue_start(3, 4, 0, 4, 16'h5A5A);
    queue_advances(5);
    // Vertical line stepping up.
    queue_start(10, 2, 10, 0, 16'h8001);
    queue_advances(3);

    // Random part: mostly complete lines with short deltas and random
    // placement, some cut short by a restart, some followed by idle
    // advances, and now and then a line of any length.
    while (words_queued < RANDOM_WORDS) begin
      xs = $urandom_range(0, COORD_MAX);
      ys = $urandom_range(0, COORD_MAX);
      if ($urandom_range(0, 39) == 0) begin
        xe = $urandom_range(0, COORD_MAX);
        ye = $urandom_range(0, COORD_MAX);
      end else if ($urandom_range(0, 29) == 0) begin
        xe = xs;
        ye = ys;
      end else begin
        xe = clamp_coord(xs + $urandom_range(0, 24) - 12);
        ye = clamp_coord(ys + $urandom_range(0, 24) - 12);
      end
      major = (xe > xs ? xe - xs : xs - xe);
      if ((ye > ys ? ye - ys : ys - ye) > major) major = (ye > ys ? ye - ys : ys - ye);
      case ($urandom_range(0, 19))
        0, 1, 2: n_adv = $urandom_range(0, major);
        3, 4, 5: n_adv = major + 1 + $urandom_range(1, 3);
        default: n_adv = major + 1;
      endcase
      queue_start(xs, ys, xe, ye, $urandom);
      queue_advances(n_adv);
      words_queued += 1 + ((n_adv < major + 1) ? n_adv : major + 1);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the sender to run dry, then for the last pixels to drain.
    do @(negedge clk); while (pending_words.size() != 0 || in_valid);
    drain = 0;
    while (expected_pixels.size() != 0 && drain < 5000) begin
      @(negedge clk);
      drain++;
    end
    repeat (4) @(negedge clk);
    if (expected_pixels.size() != 0)
      report_mismatch($sformatf("%0d expected pixels never came out",
                                expected_pixels.size()));

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Generous bound on the whole run, far beyond the slowest legal one.
  initial begin : watchdog
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule
